FILE: design/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants for the PCX RLE pixel decoder
// Byte classes, register indexes and the entry format of the front-to-back
// queue.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [BYTE_W-1:0] RUN_HEADER_MIN    = 8'd193;
  localparam logic [BYTE_W-1:0] RUN_BASE          = 8'd192;
  localparam logic [BYTE_W-1:0] TRANSPARENT_COLOR = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_REMAP = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic                  is_header;
    logic [RUN_W-1:0]      run_len;
    logic [BYTE_W-1:0]     color;
  } rpd_entry_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
  } rpd_dims_t;

endpackage

FILE: design/rpd_in_if.sv
// ----------------------------------------------------------------------------
// rpd_in_if: compressed byte channel
// One stream byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpd_in_if;
  import rpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: design/rpd_out_if.sv
// ----------------------------------------------------------------------------
// rpd_out_if: decoded pixel channel
// One pixel per word with its address and end flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpd_out_if;
  import rpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_color;
  logic [ADDR_W-1:0] pixel_address;
  logic              run_last;
  logic              image_done;

  modport source (output valid, output pixel_color, output pixel_address,
                  output run_last, output image_done, input ready);
  modport sink (input valid, input pixel_color, input pixel_address,
                input run_last, input image_done, output ready);
endinterface

FILE: design/rpd_cfg_if.sv
// ----------------------------------------------------------------------------
// rpd_cfg_if: configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpd_cfg_if;
  import rpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/pcx_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder_unit: 8-bit PCX run-length pixel decoder
// Expands literal and run-coded bytes into addressed pixels, with a
// transparent color remap and an end of image after the configured height.
//
//  channel  dir  word                                            
//  cfg      in   index, data (width / height / transparent remap)
//  stream   in   stream_byte                                     
//  pixels   out  pixel_color, pixel_address, run_last, image_done
//
// A literal byte gives one pixel; a run of n pixels is expanded in the
// back end, one pixel per cycle into the output register unless pixels stalls.
// The front takes one byte per cycle until the four-entry queue fills;
// a header byte is only held by the back end and emits no pixel.
// A stall on pixels holds the back end; the queue keeps the front going.
// rst is synchronous; it clears position, run state and the queue, and sets
// width and height to one and the transparent remap to zero.
module pcx_rle_pixel_decoder_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst,
  rpd_cfg_if.sink    cfg,
  rpd_in_if.sink     stream,
  rpd_out_if.source  pixels
);
  import rpd_pkg::*;

  rpd_dims_t  dims;
  rpd_entry_t push_data;
  rpd_entry_t head;
  logic       push;
  logic       full;
  logic       pop;
  logic       q_valid;

  rpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stream    (stream),
    .full      (full),
    .push      (push),
    .push_data (push_data),
    .dims      (dims)
  );

  rpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .q_valid   (q_valid),
    .head      (head)
  );

  rpd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .dims    (dims),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .pixels  (pixels)
  );

endmodule

FILE: design/rpd_front.sv
// ----------------------------------------------------------------------------
// rpd_front: byte classifier and configuration registers
// Takes stream bytes, splits run headers from color bytes, applies the
// transparent remap and pushes one entry per byte into the queue.
// ----------------------------------------------------------------------------
module rpd_front (
  input  logic               clk,
  input  logic               rst,
  rpd_cfg_if.sink            cfg,
  rpd_in_if.sink             stream,
  input  logic               full,
  output logic               push,
  output rpd_pkg::rpd_entry_t push_data,
  output rpd_pkg::rpd_dims_t  dims
);
  import rpd_pkg::*;

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [BYTE_W-1:0]     transparent_remap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= CFG_DATA_W'(1);
      image_height      <= CFG_DATA_W'(1);
      transparent_remap <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:       image_width       <= cfg.data;
        REG_IMAGE_HEIGHT:      image_height      <= cfg.data;
        REG_TRANSPARENT_REMAP: transparent_remap <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign dims.width  = image_width;
  assign dims.height = image_height;

  assign stream.ready = !full;
  assign push         = stream.valid && !full;

  // the back decides whether a header byte is really a color byte
  always_comb begin
    push_data.is_header = (stream.stream_byte >= RUN_HEADER_MIN);
    push_data.run_len   = RUN_W'(stream.stream_byte - RUN_BASE);
    push_data.color     = (stream.stream_byte == TRANSPARENT_COLOR) ?
                          transparent_remap : stream.stream_byte;
  end

endmodule

FILE: design/rpd_queue.sv
// ----------------------------------------------------------------------------
// rpd_queue: short entry queue between front and back
// Lets the classifier keep taking bytes while a run is being expanded.
// ----------------------------------------------------------------------------
module rpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rpd_pkg::rpd_entry_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                q_valid,
  output rpd_pkg::rpd_entry_t head
);
  import rpd_pkg::*;

  rpd_entry_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/rpd_back.sv
// ----------------------------------------------------------------------------
// rpd_back: run expander and pixel position tracker
// Pops queue entries, holds the pending run, emits one pixel per cycle into
// the output register unless pixels stalls, and tracks column, row and linear address.
// ----------------------------------------------------------------------------
module rpd_back #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  rpd_pkg::rpd_dims_t  dims,
  input  logic                q_valid,
  input  rpd_pkg::rpd_entry_t head,
  output logic                pop,
  rpd_out_if.source           pixels
);
  import rpd_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;

  logic                awaiting;
  logic                awaiting_next;
  logic [RUN_W-1:0]    pending;
  logic [RUN_W-1:0]    pending_next;
  logic [RUN_W-1:0]    cnt;
  logic [BYTE_W-1:0]   color;
  logic [DIM_W-1:0]    column;
  logic [DIM_W-1:0]    row;
  logic [ADDR_W-1:0]   address;

  logic [CMP_W-1:0]    w_ext;
  logic [CMP_W-1:0]    h_ext;
  logic [DIM_W-1:0]    width_c;
  logic [DIM_W-1:0]    height_c;
  logic                complete;
  logic                out_free;
  logic                cur_valid;
  logic [BYTE_W-1:0]   cur_color;
  logic [RUN_W-1:0]    cur_count;
  logic                emit;
  logic [DIM_W-1:0]    col_inc;
  logic                wrap;
  logic [DIM_W-1:0]    column_next;
  logic [DIM_W-1:0]    row_next;
  logic                done;

  // zero counts as one, anything above the limit counts as the limit
  always_comb begin
    w_ext = CMP_W'(dims.width);
    h_ext = CMP_W'(dims.height);
    if (w_ext == '0) begin
      width_c = DIM_W'(1);
    end else if (w_ext > CMP_W'(MAX_DIM)) begin
      width_c = DIM_W'(MAX_DIM);
    end else begin
      width_c = DIM_W'(w_ext);
    end
    if (h_ext == '0) begin
      height_c = DIM_W'(1);
    end else if (h_ext > CMP_W'(MAX_DIM)) begin
      height_c = DIM_W'(MAX_DIM);
    end else begin
      height_c = DIM_W'(h_ext);
    end
  end

  assign complete = (row >= height_c);
  assign out_free = !pixels.valid || pixels.ready;

  always_comb begin
    cur_valid     = 1'b0;
    cur_color     = color;
    cur_count     = cnt;
    pop           = 1'b0;
    awaiting_next = awaiting;
    pending_next  = pending;
    if (cnt != '0) begin
      cur_valid = 1'b1;
    end else if (q_valid) begin
      if (complete) begin
        // drop everything after the final row
        pop = 1'b1;
      end else if (awaiting) begin
        if (out_free) begin
          pop           = 1'b1;
          cur_valid     = 1'b1;
          cur_color     = head.color;
          cur_count     = pending;
          awaiting_next = 1'b0;
          pending_next  = '0;
        end
      end else if (head.is_header) begin
        pop           = 1'b1;
        awaiting_next = 1'b1;
        pending_next  = head.run_len;
      end else if (out_free) begin
        pop       = 1'b1;
        cur_valid = 1'b1;
        cur_color = head.color;
        cur_count = RUN_W'(1);
      end
    end
  end

  assign emit        = cur_valid && out_free;
  assign col_inc     = column + 1'b1;
  assign wrap        = (col_inc >= width_c);
  assign column_next = wrap ? '0 : col_inc;
  assign row_next    = wrap ? row + 1'b1 : row;
  assign done        = (row_next >= height_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting     <= 1'b0;
      pending      <= '0;
      cnt          <= '0;
      column       <= '0;
      row          <= '0;
      address      <= '0;
      pixels.valid <= 1'b0;
    end else begin
      awaiting <= awaiting_next;
      pending  <= pending_next;
      if (emit) begin
        cnt          <= done ? '0 : cur_count - 1'b1;
        column       <= column_next;
        row          <= row_next;
        address      <= address + 1'b1;
        pixels.valid <= 1'b1;
      end else if (pixels.ready) begin
        pixels.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      color                <= cur_color;
      pixels.pixel_color   <= cur_color;
      pixels.pixel_address <= address;
      pixels.run_last      <= (cur_count == RUN_W'(1)) || done;
      pixels.image_done    <= done;
    end
  end

`ifndef NO_ASSERTIONS
  a_run_not_past_end: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> !complete)
    else $error("run still active after the final row");

  a_run_excludes_header: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> !awaiting)
    else $error("run active while a color byte is still due");

  a_no_pop_in_run: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> !pop)
    else $error("queue popped during a run");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from an empty queue");

  a_emit_shows_word: assert property (@(posedge clk) disable iff (rst)
    emit |=> pixels.valid)
    else $error("emitted pixel not presented");
`endif

endmodule
